### rtl/plasma_led_pattern_generator_assert.svh
// Assertion macros for the plasma LED pattern generator.
// Used by the modules that check their own control logic; needs no package.
`ifndef PLASMA_LED_PATTERN_GENERATOR_ASSERT_SVH
`define PLASMA_LED_PATTERN_GENERATOR_ASSERT_SVH

// Condition in one cycle implies a consequence in the same cycle.
`define PLG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define PLG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/plg_pkg.sv
// Shared types, constants and the sine table for the plasma LED pattern generator.
// No dependencies; the RTL modules refer to it by scoped names.
`timescale 1ns / 1ps

package plg_pkg;

  // Sine table resolution; the table is built from a quarter wave.
  localparam int SINE_TABLE_BITS = 10;
  localparam int TABLE_SIZE      = 1 << SINE_TABLE_BITS;
  localparam int TABLE_HALF      = TABLE_SIZE / 2;
  localparam int TABLE_QUARTER   = TABLE_SIZE / 4;
  localparam int QIDX_W          = SINE_TABLE_BITS - 1;

  localparam int STRIP_MAX_DEF = 64;
  localparam int PIX_W         = 6;
  localparam int PADDR_W       = 5;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_STRIP_LEN    = 3'd0;
  localparam logic [2:0] REG_TIME_ONE     = 3'd1;
  localparam logic [2:0] REG_TIME_TWO     = 3'd2;
  localparam logic [2:0] REG_TIME_THREE   = 3'd3;
  localparam logic [2:0] REG_SPACE_ONE    = 3'd4;
  localparam logic [2:0] REG_SPACE_TWO    = 3'd5;
  localparam logic [2:0] REG_SPACE_THREE  = 3'd6;

  // Register reset values
  localparam logic [6:0]  STRIP_LEN_RST   = 7'd12;
  localparam logic [15:0] TIME_ONE_RST    = 16'd1565;
  localparam logic [15:0] TIME_TWO_RST    = 16'd2034;
  localparam logic [15:0] TIME_THREE_RST  = 16'd1095;
  localparam logic [15:0] SPACE_ONE_RST   = 16'd3129;
  localparam logic [15:0] SPACE_TWO_RST   = 16'd1565;
  localparam logic [15:0] SPACE_THREE_RST = 16'd2503;

  // Turn offsets for green and blue
  localparam logic [15:0] THIRD_TURN     = 16'd21845;
  localparam logic [15:0] TWO_THIRD_TURN = 16'd43691;

  // Sum offset and reciprocal of 3 (exact floor for values below 2^19)
  localparam logic signed [17:0] SUM_OFFSET = 18'sd49152;
  localparam logic [17:0]        DIV3_MUL   = 18'd174763;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // Configuration register file contents
  typedef struct packed {
    logic [6:0]  strip_len;
    logic [15:0] time_step_one;
    logic [15:0] time_step_two;
    logic [15:0] time_step_three;
    logic [15:0] space_step_one;
    logic [15:0] space_step_two;
    logic [15:0] space_step_three;
  } plg_cfg_t;

  // Per-pixel tag carried alongside the datapath
  typedef struct packed {
    logic [PIX_W-1:0] idx;
    logic             last;
    logic             blank;
  } plg_meta_t;

  // One pixel issued by the frame sequencer
  typedef struct packed {
    logic        valid;
    plg_meta_t   meta;
    logic [15:0] phase_one;
    logic [15:0] phase_two;
    logic [15:0] phase_three;
  } plg_issue_t;

  typedef logic [14:0] qsine_tab_t [TABLE_QUARTER+1];

  // Quarter-wave Q14 sine via Q30 Taylor series, evaluated at elaboration
  function automatic qsine_tab_t build_qsine();
    qsine_tab_t        tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    for (int m = 0; m <= TABLE_QUARTER; m++) begin
      x    = (PI_Q30 * 64'd2 * 64'(m)) / TABLE_SIZE;
      x2   = (x * x) >> 30;
      term = x;
      acc  = $signed(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc = acc - $signed(term);
        else            acc = acc + $signed(term);
      end
      if (acc < 0) acc = 0;
      acc = (acc + 64'sd32768) >>> 16;
      if (acc > 64'sd16384) acc = 64'sd16384;
      tab[m] = 15'(acc);
    end
    return tab;
  endfunction

  localparam qsine_tab_t QSINE = build_qsine();

  // Q14 sine of a 16-bit turn, top table bits select the entry
  function automatic logic signed [15:0] sine_of(input logic [15:0] phase);
    logic [SINE_TABLE_BITS-1:0] k;
    logic [QIDX_W-1:0]          m;
    logic [QIDX_W-1:0]          mm;
    logic signed [15:0]         v;
    k = phase[15:16-SINE_TABLE_BITS];
    m = k[QIDX_W-1:0];
    if (m > QIDX_W'(TABLE_QUARTER)) mm = QIDX_W'(TABLE_HALF - 32'(m));
    else                            mm = m;
    v = signed'(16'(QSINE[mm]));
    return k[SINE_TABLE_BITS-1] ? -v : v;
  endfunction

endpackage

### rtl/plg_regs.sv
// APB-style configuration register file for the plasma LED pattern generator.
// Depends on plg_pkg for register indexes, reset values and plg_cfg_t.
`timescale 1ns / 1ps

module plg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [plg_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output plg_pkg::plg_cfg_t           cfg
);

  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.strip_len        <= plg_pkg::STRIP_LEN_RST;
      cfg.time_step_one    <= plg_pkg::TIME_ONE_RST;
      cfg.time_step_two    <= plg_pkg::TIME_TWO_RST;
      cfg.time_step_three  <= plg_pkg::TIME_THREE_RST;
      cfg.space_step_one   <= plg_pkg::SPACE_ONE_RST;
      cfg.space_step_two   <= plg_pkg::SPACE_TWO_RST;
      cfg.space_step_three <= plg_pkg::SPACE_THREE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        plg_pkg::REG_STRIP_LEN:   cfg.strip_len        <= pwdata[6:0];
        plg_pkg::REG_TIME_ONE:    cfg.time_step_one    <= pwdata[15:0];
        plg_pkg::REG_TIME_TWO:    cfg.time_step_two    <= pwdata[15:0];
        plg_pkg::REG_TIME_THREE:  cfg.time_step_three  <= pwdata[15:0];
        plg_pkg::REG_SPACE_ONE:   cfg.space_step_one   <= pwdata[15:0];
        plg_pkg::REG_SPACE_TWO:   cfg.space_step_two   <= pwdata[15:0];
        plg_pkg::REG_SPACE_THREE: cfg.space_step_three <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      plg_pkg::REG_STRIP_LEN:   prdata = 32'(cfg.strip_len);
      plg_pkg::REG_TIME_ONE:    prdata = 32'(cfg.time_step_one);
      plg_pkg::REG_TIME_TWO:    prdata = 32'(cfg.time_step_two);
      plg_pkg::REG_TIME_THREE:  prdata = 32'(cfg.time_step_three);
      plg_pkg::REG_SPACE_ONE:   prdata = 32'(cfg.space_step_one);
      plg_pkg::REG_SPACE_TWO:   prdata = 32'(cfg.space_step_two);
      plg_pkg::REG_SPACE_THREE: prdata = 32'(cfg.space_step_three);
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

### rtl/plg_frame_seq.sv
// Frame sequencer: takes frame requests, keeps blank flag and animation phases,
// and issues one pixel per advancing cycle. Depends on plg_pkg and the assert header.
`timescale 1ns / 1ps
`include "plasma_led_pattern_generator_assert.svh"

module plg_frame_seq #(
  parameter int STRIP_MAX = plg_pkg::STRIP_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  plg_pkg::plg_cfg_t    cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 blank_press,
  input  logic                 resume_press,
  input  logic                 adv,
  output plg_pkg::plg_issue_t  issue
);

  localparam int IDX_W = (STRIP_MAX > 1) ? $clog2(STRIP_MAX) : 1;

  logic             busy;
  logic             blanked;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] last_idx;
  logic [15:0]      phase_one;
  logic [15:0]      phase_two;
  logic [15:0]      phase_three;
  logic [15:0]      acc_one;
  logic [15:0]      acc_two;
  logic [15:0]      acc_three;

  logic             accept;
  logic             fire;
  logic             at_last;
  logic             blanked_next;
  logic [IDX_W-1:0] last_idx_next;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign fire     = busy && adv;
  assign at_last  = (idx == last_idx);

  // Resume clears first, then blank sets
  assign blanked_next = (blanked && !resume_press) || blank_press;

  // Clamp the pixel count to 1..STRIP_MAX, keep the final index
  always_comb begin
    if (cfg.strip_len == 7'd0)
      last_idx_next = '0;
    else if (cfg.strip_len > 7'(STRIP_MAX))
      last_idx_next = IDX_W'(STRIP_MAX - 1);
    else
      last_idx_next = IDX_W'(cfg.strip_len - 7'd1);
  end

  // Control: busy flag, blank flag and animation phases
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      blanked     <= 1'b0;
      phase_one   <= '0;
      phase_two   <= '0;
      phase_three <= '0;
    end else if (accept) begin
      busy    <= 1'b1;
      blanked <= blanked_next;
    end else if (fire && at_last) begin
      busy <= 1'b0;
      if (!blanked) begin
        phase_one   <= phase_one + cfg.time_step_one;
        phase_two   <= phase_two + cfg.time_step_two;
        phase_three <= phase_three + cfg.time_step_three;
      end
    end
  end

  // Pixel index and spatial phase accumulators
  always_ff @(posedge clk) begin
    if (accept) begin
      idx       <= '0;
      last_idx  <= last_idx_next;
      acc_one   <= phase_one;
      acc_two   <= phase_two;
      acc_three <= phase_three;
    end else if (fire) begin
      idx       <= idx + 1'b1;
      acc_one   <= acc_one + cfg.space_step_one;
      acc_two   <= acc_two + cfg.space_step_two;
      acc_three <= acc_three + cfg.space_step_three;
    end
  end

  // Pixel handed to the datapath
  assign issue.valid       = busy;
  assign issue.meta.idx    = plg_pkg::PIX_W'(idx);
  assign issue.meta.last   = at_last;
  assign issue.meta.blank  = blanked;
  assign issue.phase_one   = acc_one;
  assign issue.phase_two   = acc_two;
  assign issue.phase_three = acc_three;

  `PLG_ASSERT_NEXT(a_last_ends_frame, clk, rst, fire && at_last, !busy, "frame did not end")
  `PLG_ASSERT_NEXT(a_idx_steps, clk, rst, fire && !at_last, idx == $past(idx) + 1'b1, "idx skip")
  `PLG_ASSERT_SAME(a_idx_in_frame, clk, rst, busy, idx <= last_idx, "idx beyond frame end")
  `PLG_ASSERT_NEXT(a_phase_hold, clk, rst, !(fire && at_last && !blanked),
                   $stable(phase_one) && $stable(phase_two) && $stable(phase_three),
                   "phase moved outside running frame end")

endmodule

### rtl/plg_pixel_pipe.sv
// Pixel datapath: phase register, sine sum, turn normalize, color and output register.
// Depends on plg_pkg for the sine function and pixel tag types.
`timescale 1ns / 1ps

module plg_pixel_pipe (
  input  logic                       clk,
  input  logic                       rst,
  input  plg_pkg::plg_issue_t        issue,
  output logic                       adv,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [plg_pkg::PIX_W-1:0]  pixel_index,
  output logic [7:0]                 red,
  output logic [7:0]                 green,
  output logic [7:0]                 blue,
  output logic                       last_pixel
);

  // 128 + floor(127 * s / 16384) for a Q14 sine
  function automatic logic [7:0] colour_of(input logic [15:0] turn);
    logic signed [15:0] s;
    logic signed [23:0] prod;
    logic signed [9:0]  fl;
    s    = plg_pkg::sine_of(turn);
    prod = (24'(s) <<< 7) - 24'(s);
    fl   = 10'(prod >>> 14);
    return 8'(fl + 10'sd128);
  endfunction

  logic                s1_valid, s2_valid, s3_valid, s4_valid;
  plg_pkg::plg_meta_t  s1_meta, s2_meta, s3_meta;
  logic [15:0]         s1_p1, s1_p2, s1_p3;
  logic signed [16:0]  s2_sum;
  logic [15:0]         s3_turn;

  logic signed [16:0]  sum_next;
  logic signed [17:0]  sum_ofs;
  logic [17:0]         dbl;
  logic [34:0]         prod;

  // Whole pipe moves when the output register is free or being taken
  assign adv       = !s4_valid || out_ready;
  assign out_valid = s4_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // Sum of three sines
  assign sum_next = 17'(plg_pkg::sine_of(s1_p1)) + 17'(plg_pkg::sine_of(s1_p2))
                  + 17'(plg_pkg::sine_of(s1_p3));

  // turn = (sum + 49152) * 2 / 3, wrapped to 16 bits
  assign sum_ofs = 18'(s2_sum) + plg_pkg::SUM_OFFSET;
  assign dbl     = {sum_ofs[16:0], 1'b0};
  assign prod    = 35'(dbl) * 35'(plg_pkg::DIV3_MUL);

  // Payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_meta <= issue.meta;
      s1_p1   <= issue.phase_one;
      s1_p2   <= issue.phase_two;
      s1_p3   <= issue.phase_three;

      s2_meta <= s1_meta;
      s2_sum  <= sum_next;

      s3_meta <= s2_meta;
      s3_turn <= prod[34:19];

      pixel_index <= s3_meta.idx;
      last_pixel  <= s3_meta.last;
      if (s3_meta.blank) begin
        red   <= 8'd0;
        green <= 8'd0;
        blue  <= 8'd0;
      end else begin
        red   <= colour_of(s3_turn);
        green <= colour_of(s3_turn + plg_pkg::THIRD_TURN);
        blue  <= colour_of(s3_turn + plg_pkg::TWO_THIRD_TURN);
      end
    end
  end

endmodule

### rtl/plasma_led_pattern_generator.sv
// Top level of the plasma LED pattern generator.
// Instantiates plg_regs, plg_frame_seq and plg_pixel_pipe; depends on plg_pkg.
//
// Usage:
//   Configuration: APB-style port, registers at byte address 4*i (strip length,
//   time steps one..three, space steps one..three); pready is tied high.
//   Input channel (in_valid/in_ready): one beat is a frame request carrying
//   blank_press and resume_press. Output channel (out_valid/out_ready): one
//   beat per pixel with pixel_index, red, green, blue and last_pixel set on
//   the final pixel of the frame.
//   Frame: after its request beat, the first pixel of a frame passes the phase,
//   sum, turn and output registers. A frame of N pixels (N = strip length
//   clamped to 1..STRIP_MAX) issues one pixel per cycle while the pipeline
//   advances, and the next request is taken the cycle after the last pixel is
//   issued; the pixel counter of the frame sequencer ends the frame.
//   Stall: when out_ready is low with a pixel waiting, the whole pixel
//   pipeline holds and issue pauses; no pixel is dropped.
//   Reset (rst, synchronous): registers return to defaults, phases clear,
//   animation runs (not blanked), both channels empty.
`timescale 1ns / 1ps

module plasma_led_pattern_generator #(
  parameter int STRIP_MAX = plg_pkg::STRIP_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [plg_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        blank_press,
  input  logic                        resume_press,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [plg_pkg::PIX_W-1:0]   pixel_index,
  output logic [7:0]                  red,
  output logic [7:0]                  green,
  output logic [7:0]                  blue,
  output logic                        last_pixel
);

  plg_pkg::plg_cfg_t   cfg;
  plg_pkg::plg_issue_t issue;
  logic                adv;

  plg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  plg_frame_seq #(
    .STRIP_MAX (STRIP_MAX)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .blank_press  (blank_press),
    .resume_press (resume_press),
    .adv          (adv),
    .issue        (issue)
  );

  plg_pixel_pipe u_pipe (
    .clk         (clk),
    .rst         (rst),
    .issue       (issue),
    .adv         (adv),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_index (pixel_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .last_pixel  (last_pixel)
  );

endmodule
